// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the schedule table RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising edge outside reset.
`define ASSERT_HOLDS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The condition must never be true at a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/wsched_pkg.sv =====
// Shared types, codes and helpers for the weekly event schedule table.
// Used by every module of the block; depends on nothing.
package wsched_pkg;

	localparam int EVENT_SLOTS_DEF = 32;
	localparam int LIGHT_COUNT_DEF = 32;
	localparam int QUEUE_DEPTH = 2;

	localparam int OP_W = 2;
	localparam int LIGHT_W = 8;
	localparam int DAY_W = 4;
	localparam int MINUTE_W = 11;
	localparam int TODAY_W = 3;
	localparam int KIND_W = 2;
	localparam int STATUS_W = 2;

	// Input operations.
	localparam logic [OP_W-1:0] OP_ON = 2'd0;
	localparam logic [OP_W-1:0] OP_OFF = 2'd1;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
	localparam logic [OP_W-1:0] OP_TICK = 2'd3;

	// Result kinds.
	localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CMD = 2'd1;
	localparam logic [KIND_W-1:0] KIND_NONE = 2'd2;

	// Status codes.
	localparam logic [STATUS_W-1:0] STAT_OK = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_BAD_ID = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL = 2'd2;

	// Day codes and the days that bound the weekday and weekend groups.
	localparam logic [DAY_W-1:0] DAY_EVERYDAY = 4'd7;
	localparam logic [DAY_W-1:0] DAY_WEEKDAY = 4'd8;
	localparam logic [DAY_W-1:0] DAY_WEEKEND = 4'd9;
	localparam logic [TODAY_W-1:0] DOW_SUNDAY = 3'd0;
	localparam logic [TODAY_W-1:0] DOW_MONDAY = 3'd1;
	localparam logic [TODAY_W-1:0] DOW_FRIDAY = 3'd5;
	localparam logic [TODAY_W-1:0] DOW_SATURDAY = 3'd6;

	// Work kinds that the front end hands to the back end.
	typedef enum logic [1:0] {
		CMD_SCHED = 2'd0,
		CMD_REJECT = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_TICK = 2'd3
	} cmd_kind_t;

	// One classified item in the queue. For a tick, minute carries the current minute.
	typedef struct packed {
		cmd_kind_t ctype;
		logic on;
		logic [LIGHT_W-1:0] light;
		logic [DAY_W-1:0] day;
		logic [MINUTE_W-1:0] minute;
		logic [TODAY_W-1:0] today;
	} cmd_t;

	// One stored schedule entry.
	typedef struct packed {
		logic [LIGHT_W-1:0] light;
		logic [DAY_W-1:0] day;
		logic [MINUTE_W-1:0] minute;
		logic on;
	} entry_t;

	// True when an entry with this day code is due on the given day of the week.
	function automatic logic day_matches(input logic [DAY_W-1:0] code,
			input logic [TODAY_W-1:0] today);
		logic hit;
		hit = (code == DAY_EVERYDAY)
			|| (code == {1'b0, today})
			|| ((code == DAY_WEEKEND) && ((today == DOW_SUNDAY) || (today == DOW_SATURDAY)))
			|| ((code == DAY_WEEKDAY) && (today >= DOW_MONDAY) && (today <= DOW_FRIDAY));
		return hit;
	endfunction

endpackage

// ===== rtl/wsched_front.sv =====
// Front end of the schedule table: takes input transfers and classifies them.
// Depends on wsched_pkg; feeds wsched_fifo.
module wsched_front #(
	parameter int LIGHT_COUNT = wsched_pkg::LIGHT_COUNT_DEF
) (
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [wsched_pkg::OP_W-1:0]         op,
	input  logic [wsched_pkg::LIGHT_W-1:0]      light_id,
	input  logic [wsched_pkg::DAY_W-1:0]        day_code,
	input  logic [wsched_pkg::MINUTE_W-1:0]     minute,
	input  logic [wsched_pkg::TODAY_W-1:0]      today,
	input  logic [wsched_pkg::MINUTE_W-1:0]     now_minute,
	input  logic                                q_full,
	output logic                                push,
	output wsched_pkg::cmd_t                    push_cmd
);

	logic bad_id;

	// The bound is compared one bit wider so that a count of 256 still fits.
	assign bad_id = ({1'b0, light_id} >= (wsched_pkg::LIGHT_W + 1)'(LIGHT_COUNT));

	assign in_stall = q_full;
	assign push = in_valid && !q_full;

	always_comb begin
		push_cmd.on = (op == wsched_pkg::OP_ON);
		push_cmd.light = light_id;
		push_cmd.day = day_code;
		push_cmd.minute = minute;
		push_cmd.today = today;
		unique case (op)
			wsched_pkg::OP_ON, wsched_pkg::OP_OFF: begin
				push_cmd.ctype = bad_id ? wsched_pkg::CMD_REJECT : wsched_pkg::CMD_SCHED;
			end
			wsched_pkg::OP_REMOVE: begin
				push_cmd.ctype = wsched_pkg::CMD_REMOVE;
			end
			default: begin
				push_cmd.ctype = wsched_pkg::CMD_TICK;
				push_cmd.minute = now_minute;
			end
		endcase
	end

endmodule

// ===== rtl/wsched_fifo.sv =====
// Short command queue between the front and back ends of the schedule table.
// Depends on wsched_pkg and assert_macros.svh.
`include "assert_macros.svh"
module wsched_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  wsched_pkg::cmd_t  push_cmd,
	output logic              full,
	input  logic              pop,
	output wsched_pkg::cmd_t  pop_cmd,
	output logic              empty
);

	localparam int DEPTH = wsched_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	wsched_pkg::cmd_t slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign pop_cmd = slots_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] n;
		n = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
		return n;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	`ASSERT_NEVER(a_no_pop_empty, clk, arst_n, pop && empty, "queue popped while empty")
	`ASSERT_NEVER(a_no_push_full, clk, arst_n, push && full, "queue pushed while full")

endmodule

// ===== rtl/wsched_back.sv =====
// Back end of the schedule table: slot scan, entry memory, valid bits and result register.
// Depends on wsched_pkg and assert_macros.svh; drains wsched_fifo.
`include "assert_macros.svh"
module wsched_back #(
	parameter int EVENT_SLOTS = wsched_pkg::EVENT_SLOTS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                q_empty,
	input  wsched_pkg::cmd_t                    q_cmd,
	output logic                                pop,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [wsched_pkg::KIND_W-1:0]       kind,
	output logic [wsched_pkg::STATUS_W-1:0]     status,
	output logic [wsched_pkg::LIGHT_W-1:0]      cmd_light,
	output logic                                cmd_on,
	output logic                                last
);

	localparam int SLOT_W = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_FINAL = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic [SLOT_W-1:0] idx_q, idx_d;
	wsched_pkg::cmd_t cmd_q;
	logic [EVENT_SLOTS-1:0] valid_q;
	wsched_pkg::entry_t mem [EVENT_SLOTS];
	wsched_pkg::entry_t rd_q;
	wsched_pkg::entry_t wr_entry;

	logic pend_q;
	logic [wsched_pkg::LIGHT_W-1:0] pend_light_q;
	logic pend_on_q;

	logic out_valid_q;
	logic [wsched_pkg::KIND_W-1:0] kind_q;
	logic [wsched_pkg::STATUS_W-1:0] status_q;
	logic [wsched_pkg::LIGHT_W-1:0] light_q;
	logic on_q;
	logic last_q;

	logic idx_last, cur_valid, hit_remove, hit_tick, can_emit;
	logic emit, e_last, e_on;
	logic [wsched_pkg::KIND_W-1:0] e_kind;
	logic [wsched_pkg::STATUS_W-1:0] e_status;
	logic [wsched_pkg::LIGHT_W-1:0] e_light;
	logic wr_en, set_valid, clr_valid, pend_load, pend_clear;

	assign idx_last = (idx_q == SLOT_W'(EVENT_SLOTS - 1));
	assign cur_valid = valid_q[idx_q];
	assign hit_remove = cur_valid && (rd_q.light == cmd_q.light) && (rd_q.day == cmd_q.day)
		&& (rd_q.minute == cmd_q.minute);
	assign hit_tick = cur_valid && wsched_pkg::day_matches(rd_q.day, cmd_q.today)
		&& (rd_q.minute == cmd_q.minute);
	assign can_emit = !out_valid_q || !out_stall;

	assign wr_entry.light = cmd_q.light;
	assign wr_entry.day = cmd_q.day;
	assign wr_entry.minute = cmd_q.minute;
	assign wr_entry.on = cmd_q.on;

	always_comb begin
		state_d = state_q;
		idx_d = idx_q;
		pop = 1'b0;
		emit = 1'b0;
		e_kind = wsched_pkg::KIND_STATUS;
		e_status = wsched_pkg::STAT_OK;
		e_light = '0;
		e_on = 1'b0;
		e_last = 1'b1;
		wr_en = 1'b0;
		set_valid = 1'b0;
		clr_valid = 1'b0;
		pend_load = 1'b0;
		pend_clear = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				idx_d = '0;
				if (!q_empty) begin
					pop = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (can_emit) begin
					unique case (cmd_q.ctype)
						wsched_pkg::CMD_REJECT: begin
							emit = 1'b1;
							e_status = wsched_pkg::STAT_BAD_ID;
							state_d = ST_IDLE;
							idx_d = '0;
						end
						wsched_pkg::CMD_SCHED: begin
							if (!cur_valid) begin
								wr_en = 1'b1;
								set_valid = 1'b1;
								emit = 1'b1;
								state_d = ST_IDLE;
								idx_d = '0;
							end else if (idx_last) begin
								emit = 1'b1;
								e_status = wsched_pkg::STAT_FULL;
								state_d = ST_IDLE;
								idx_d = '0;
							end else begin
								idx_d = idx_q + SLOT_W'(1);
							end
						end
						wsched_pkg::CMD_REMOVE: begin
							clr_valid = hit_remove;
							if (idx_last) begin
								emit = 1'b1;
								state_d = ST_IDLE;
								idx_d = '0;
							end else begin
								idx_d = idx_q + SLOT_W'(1);
							end
						end
						default: begin
							// A new hit releases the one held back; the last hit waits for the end.
							if (hit_tick) begin
								pend_load = 1'b1;
								if (pend_q) begin
									emit = 1'b1;
									e_kind = wsched_pkg::KIND_CMD;
									e_light = pend_light_q;
									e_on = pend_on_q;
									e_last = 1'b0;
								end
							end
							if (idx_last) begin
								state_d = ST_FINAL;
								idx_d = '0;
							end else begin
								idx_d = idx_q + SLOT_W'(1);
							end
						end
					endcase
				end
			end
			ST_FINAL: begin
				if (can_emit) begin
					emit = 1'b1;
					pend_clear = 1'b1;
					state_d = ST_IDLE;
					if (pend_q) begin
						e_kind = wsched_pkg::KIND_CMD;
						e_light = pend_light_q;
						e_on = pend_on_q;
					end else begin
						e_kind = wsched_pkg::KIND_NONE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
				idx_d = '0;
			end
		endcase
	end

	// Entry memory: one write port, one registered read port that follows the next index.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[idx_q] <= wr_entry;
		end
		rd_q <= mem[idx_d];
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= q_cmd;
		end
		if (pend_load) begin
			pend_light_q <= rd_q.light;
			pend_on_q <= rd_q.on;
		end
		if (emit) begin
			kind_q <= e_kind;
			status_q <= e_status;
			light_q <= e_light;
			on_q <= e_on;
			last_q <= e_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			valid_q <= '0;
			pend_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q <= idx_d;
			if (set_valid) begin
				valid_q[idx_q] <= 1'b1;
			end else if (clr_valid) begin
				valid_q[idx_q] <= 1'b0;
			end
			if (pend_load) begin
				pend_q <= 1'b1;
			end else if (pend_clear) begin
				pend_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign kind = kind_q;
	assign status = status_q;
	assign cmd_light = light_q;
	assign cmd_on = on_q;
	assign last = last_q;

	`ASSERT_HOLDS(a_none_is_last, clk, arst_n,
		out_valid_q && (kind_q == wsched_pkg::KIND_NONE) |-> last_q,
		"no-action result without last")
	`ASSERT_HOLDS(a_idle_no_pending, clk, arst_n,
		(state_q == ST_IDLE) |-> !pend_q,
		"held tick command left over in idle")
	`ASSERT_HOLDS(a_full_means_full, clk, arst_n,
		out_valid_q && (kind_q == wsched_pkg::KIND_STATUS)
			&& (status_q == wsched_pkg::STAT_FULL) |-> (&valid_q),
		"table full reported with a free slot")

endmodule

// ===== rtl/weekly_event_schedule_table.sv =====
// Top level of the weekly event schedule table.
// Depends on wsched_pkg, wsched_front, wsched_fifo and wsched_back.
//
// Usage: one input channel (in_valid / in_stall with op, light_id, day_code, minute,
// today, now_minute) and one result channel (out_valid / out_stall with kind, status,
// cmd_light, cmd_on, last). A transfer happens on a rising edge where valid is high
// and stall is low. Every input item yields one or more results; last marks the final one.
// Items are classified on entry and land in a two-deep command queue, so the sender is
// stalled only when that queue is full. The back end then walks the slots one per cycle
// while no result is stalled, limited by the single read port of the entry memory.
// With the back end idle, a rejected schedule item passes through the command queue and the
// back end's command register before its result is registered. A schedule item stops at the
// first free slot; a remove item walks every slot; a tick walks every slot and then passes
// through a final state that emits its last result. The back end returns to its idle state
// between items, and a stalled result holds back the walk of the current item.
// Reset clears all slot valid bits at once, so the table is usable right after reset.
// When the receiver stalls, the result register holds and the slot walk pauses until it drains.
module weekly_event_schedule_table #(
	parameter int EVENT_SLOTS = wsched_pkg::EVENT_SLOTS_DEF,
	parameter int LIGHT_COUNT = wsched_pkg::LIGHT_COUNT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [wsched_pkg::OP_W-1:0]         op,
	input  logic [wsched_pkg::LIGHT_W-1:0]      light_id,
	input  logic [wsched_pkg::DAY_W-1:0]        day_code,
	input  logic [wsched_pkg::MINUTE_W-1:0]     minute,
	input  logic [wsched_pkg::TODAY_W-1:0]      today,
	input  logic [wsched_pkg::MINUTE_W-1:0]     now_minute,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [wsched_pkg::KIND_W-1:0]       kind,
	output logic [wsched_pkg::STATUS_W-1:0]     status,
	output logic [wsched_pkg::LIGHT_W-1:0]      cmd_light,
	output logic                                cmd_on,
	output logic                                last
);

	// Classified commands travel from the front end through the queue to the back end.
	logic push, q_full, q_empty, pop;
	wsched_pkg::cmd_t push_cmd, pop_cmd;

	wsched_front #(
		.LIGHT_COUNT(LIGHT_COUNT)
	) u_front (
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.light_id   (light_id),
		.day_code   (day_code),
		.minute     (minute),
		.today      (today),
		.now_minute (now_minute),
		.q_full     (q_full),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	wsched_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.empty    (q_empty)
	);

	// The back end owns the table and the result register.
	wsched_back #(
		.EVENT_SLOTS(EVENT_SLOTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_cmd     (pop_cmd),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.kind      (kind),
		.status    (status),
		.cmd_light (cmd_light),
		.cmd_on    (cmd_on),
		.last      (last)
	);

endmodule
